// ----- sv/pcpt_pkg.sv -----
// Package for the per-CPU preemption tracker: item types, operation and
// status codes, entry layout and the eligibility helper. No dependencies.
`default_nettype none

package pcpt_pkg;

    localparam int CPU_COUNT_DEF   = 16;
    localparam int NESTING_MAX_DEF = 255;

    // Operation codes
    localparam logic [3:0] FN_INIT      = 4'd0;
    localparam logic [3:0] FN_ONLINE    = 4'd1;
    localparam logic [3:0] FN_OFFLINE   = 4'd2;
    localparam logic [3:0] FN_IRQ_ENTER = 4'd3;
    localparam logic [3:0] FN_IRQ_EXIT  = 4'd4;
    localparam logic [3:0] FN_DISABLE   = 4'd5;
    localparam logic [3:0] FN_ENABLE    = 4'd6;
    localparam logic [3:0] FN_REQUEST   = 4'd7;
    localparam logic [3:0] FN_CANCEL    = 4'd8;
    localparam logic [3:0] FN_QUERY     = 4'd9;
    localparam logic [3:0] FN_TAKE      = 4'd10;
    localparam logic [3:0] FN_SNAPSHOT  = 4'd11;
    localparam logic [3:0] FN_CLEAR     = 4'd12;

    // Status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_NOT_INIT       = 4'd1;
    localparam logic [3:0] ST_POISONED       = 4'd2;
    localparam logic [3:0] ST_ALREADY_INIT   = 4'd3;
    localparam logic [3:0] ST_INVALID_CPU    = 4'd4;
    localparam logic [3:0] ST_OFFLINE        = 4'd5;
    localparam logic [3:0] ST_ALREADY_ONLINE = 4'd6;
    localparam logic [3:0] ST_LAST_CPU       = 4'd7;
    localparam logic [3:0] ST_BUSY           = 4'd8;
    localparam logic [3:0] ST_OVERFLOW       = 4'd9;
    localparam logic [3:0] ST_UNDERFLOW      = 4'd10;
    localparam logic [3:0] ST_NOT_ELIGIBLE   = 4'd11;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] cpu_sel;
    } t_in_item;

    typedef struct packed {
        logic [3:0] status;
        logic       eligible;
        logic [7:0] snap_irq_lvl;
        logic [7:0] snap_pre_cnt;
        logic       snap_resched_req;
        logic       snap_online;
    } t_out_item;

    // One CPU entry as held in the memory
    typedef struct packed {
        logic [7:0] irq_lvl;
        logic [7:0] pre_cnt;
        logic       resched_req;
        logic       online;
    } t_entry;

    // Control from the update logic to the memory and global flags
    typedef struct packed {
        logic mem_we;
        logic mem_clr;
        logic init_n;
        logic poison_n;
    } t_ctl;

    function automatic logic f_eligible(input t_entry e);
        return e.online && (e.irq_lvl == 8'd0) && (e.pre_cnt == 8'd0)
               && e.resched_req;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pcpt_entry_mem.sv -----
// Per-CPU entry memory: one write and one registered read port, with a
// valid bit per entry so a clear-all needs no pass over the entries. Uses pcpt_pkg.
`default_nettype none

module pcpt_entry_mem
    import pcpt_pkg::*;
#(
    parameter int DEPTH = CPU_COUNT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_clr
);

    t_entry r_mem [DEPTH];
    logic   r_vld [DEPTH];
    t_entry r_rd_data;
    logic   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // clear-all and a write may coincide (init): the write wins for its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                if (i_wr_en && (i_wr_addr == AW'(k))) begin
                    r_vld[k] <= 1'b1;
                end else if (i_clr) begin
                    r_vld[k] <= 1'b0;
                end
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ----- sv/pcpt_update.sv -----
// Event decode and entry update: gate checks, counter limits, status and
// eligibility from one entry read. Uses pcpt_pkg.
`default_nettype none

module pcpt_update
    import pcpt_pkg::*;
#(
    parameter int CPU_COUNT   = CPU_COUNT_DEF,
    parameter int NESTING_MAX = NESTING_MAX_DEF,
    parameter int TW          = $clog2(CPU_COUNT + 1)
) (
    input  wire t_in_item   i_item,
    input  wire t_entry     i_entry,
    input  wire logic [TW-1:0] i_total,
    input  wire logic       i_init,
    input  wire logic       i_poison,
    output t_entry          o_entry,
    output logic [TW-1:0]   o_total,
    output t_ctl            o_ctl,
    output t_out_item       o_result
);

    localparam int         COUNT_LIMIT = (NESTING_MAX < 255) ? NESTING_MAX : 255;
    localparam logic [7:0] LIMIT       = 8'(COUNT_LIMIT);

    logic in_range;

    assign in_range = (i_item.cpu_sel < 8'(CPU_COUNT));

    always_comb begin
        o_entry        = i_entry;
        o_total        = i_total;
        o_ctl.mem_we   = 1'b0;
        o_ctl.mem_clr  = 1'b0;
        o_ctl.init_n   = i_init;
        o_ctl.poison_n = i_poison;
        o_result       = '0;
        o_result.status = ST_OK;

        case (i_item.func)
            FN_INIT: begin
                if (i_init) begin
                    o_result.status = ST_ALREADY_INIT;
                end else if (!in_range) begin
                    o_result.status = ST_INVALID_CPU;
                end else begin
                    o_ctl.mem_clr  = 1'b1;
                    o_ctl.mem_we   = 1'b1;
                    o_entry        = '0;
                    o_entry.online = 1'b1;
                    o_total        = TW'(1);
                    o_ctl.init_n   = 1'b1;
                    o_ctl.poison_n = 1'b0;
                end
            end
            FN_CLEAR: begin
                o_ctl.mem_clr  = 1'b1;
                o_total        = '0;
                o_ctl.init_n   = 1'b0;
                o_ctl.poison_n = 1'b0;
            end
            default: begin
                if (i_item.func inside {[FN_ONLINE:FN_SNAPSHOT]}) begin
                    if (i_poison) begin
                        o_result.status = ST_POISONED;
                    end else if (!i_init) begin
                        o_result.status = ST_NOT_INIT;
                    end else if (!in_range) begin
                        o_result.status = ST_INVALID_CPU;
                    end else if (i_item.func == FN_ONLINE) begin
                        if (i_entry.online) begin
                            o_result.status = ST_ALREADY_ONLINE;
                        end else begin
                            o_entry.online = 1'b1;
                            o_ctl.mem_we   = 1'b1;
                            o_total        = TW'(i_total + TW'(1));
                        end
                    end else if (i_item.func == FN_SNAPSHOT) begin
                        o_result.snap_irq_lvl     = i_entry.irq_lvl;
                        o_result.snap_pre_cnt     = i_entry.pre_cnt;
                        o_result.snap_resched_req = i_entry.resched_req;
                        o_result.snap_online      = i_entry.online;
                    end else if (!i_entry.online) begin
                        o_result.status = ST_OFFLINE;
                    end else begin
                        case (i_item.func)
                            FN_OFFLINE: begin
                                if (i_total <= TW'(1)) begin
                                    o_result.status = ST_LAST_CPU;
                                end else if (i_entry.irq_lvl != 8'd0 ||
                                             i_entry.pre_cnt != 8'd0 ||
                                             i_entry.resched_req) begin
                                    o_result.status = ST_BUSY;
                                end else begin
                                    o_entry.online = 1'b0;
                                    o_ctl.mem_we   = 1'b1;
                                    o_total        = TW'(i_total - TW'(1));
                                end
                            end
                            FN_IRQ_ENTER: begin
                                if (i_entry.irq_lvl >= LIMIT) begin
                                    o_ctl.poison_n  = 1'b1;
                                    o_result.status = ST_OVERFLOW;
                                end else begin
                                    o_entry.irq_lvl = i_entry.irq_lvl + 8'd1;
                                    o_ctl.mem_we    = 1'b1;
                                end
                            end
                            FN_IRQ_EXIT: begin
                                if (i_entry.irq_lvl == 8'd0) begin
                                    o_ctl.poison_n  = 1'b1;
                                    o_result.status = ST_UNDERFLOW;
                                end else begin
                                    o_entry.irq_lvl   = i_entry.irq_lvl - 8'd1;
                                    o_ctl.mem_we      = 1'b1;
                                    o_result.eligible = f_eligible(o_entry);
                                end
                            end
                            FN_DISABLE: begin
                                if (i_entry.pre_cnt >= LIMIT) begin
                                    o_ctl.poison_n  = 1'b1;
                                    o_result.status = ST_OVERFLOW;
                                end else begin
                                    o_entry.pre_cnt = i_entry.pre_cnt + 8'd1;
                                    o_ctl.mem_we    = 1'b1;
                                end
                            end
                            FN_ENABLE: begin
                                if (i_entry.pre_cnt == 8'd0) begin
                                    o_ctl.poison_n  = 1'b1;
                                    o_result.status = ST_UNDERFLOW;
                                end else begin
                                    o_entry.pre_cnt   = i_entry.pre_cnt - 8'd1;
                                    o_ctl.mem_we      = 1'b1;
                                    o_result.eligible = f_eligible(o_entry);
                                end
                            end
                            FN_REQUEST: begin
                                o_entry.resched_req = 1'b1;
                                o_ctl.mem_we        = 1'b1;
                            end
                            FN_CANCEL: begin
                                o_entry.resched_req = 1'b0;
                                o_ctl.mem_we        = 1'b1;
                            end
                            FN_QUERY: begin
                                o_result.eligible = f_eligible(i_entry);
                            end
                            FN_TAKE: begin
                                if (!f_eligible(i_entry)) begin
                                    o_result.status = ST_NOT_ELIGIBLE;
                                end else begin
                                    o_entry.resched_req = 1'b0;
                                    o_ctl.mem_we        = 1'b1;
                                end
                            end
                            default: begin
                                o_result.status = ST_OK;
                            end
                        endcase
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/per_cpu_preemption_tracker_top.sv -----
// Top level of the per-CPU preemption tracker: handshakes, global flags and
// result register. Instantiates pcpt_entry_mem and pcpt_update; uses pcpt_pkg.
`default_nettype none

// Each item names an operation and a CPU and yields exactly one result item.
// The CPU entries (IRQ depth, preempt count, reschedule flag, online flag)
// sit in a one-port-read, one-port-write memory with a registered read; the
// online count, initialised flag and poison flag sit in registers. For each
// item, the edge that accepts it starts the entry read, and the next free
// edge decodes, writes the entry back and loads the result register. A new
// item is accepted only once the current one has been written back. Only one
// item is in flight, so a write-back always lands before the next read and
// no forwarding is needed. Init and clear empty every entry via per-entry
// valid bits; there is no clearing pass after reset. The next item is
// accepted while the previous result still waits in the output register.

module per_cpu_preemption_tracker_top
    import pcpt_pkg::*;
#(
    parameter int CPU_COUNT   = CPU_COUNT_DEF,
    parameter int NESTING_MAX = NESTING_MAX_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_item
);

    localparam int AW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int TW = $clog2(CPU_COUNT + 1);

    // Item in flight between read and write-back
    logic      r_pend;
    t_in_item  r_item;

    // Global state
    logic [TW-1:0] r_total;
    logic          r_init;
    logic          r_poison;

    // Result register
    logic      r_out_vld;
    t_out_item r_out;

    logic          accept;
    logic          fire;
    t_entry        rd_entry;
    t_entry        wr_entry;
    logic [TW-1:0] n_total;
    t_ctl          ctl;
    t_out_item     n_out;

    assign o_in_ready  = !r_pend;
    assign accept      = i_in_valid && !r_pend;
    // write-back needs a free result register
    assign fire        = r_pend && (!r_out_vld || i_out_ready);

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    pcpt_entry_mem #(
        .DEPTH (CPU_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_in_item.cpu_sel[AW-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (fire && ctl.mem_we),
        .i_wr_addr (r_item.cpu_sel[AW-1:0]),
        .i_wr_data (wr_entry),
        .i_clr     (fire && ctl.mem_clr)
    );

    pcpt_update #(
        .CPU_COUNT   (CPU_COUNT),
        .NESTING_MAX (NESTING_MAX),
        .TW          (TW)
    ) u_update (
        .i_item   (r_item),
        .i_entry  (rd_entry),
        .i_total  (r_total),
        .i_init   (r_init),
        .i_poison (r_poison),
        .o_entry  (wr_entry),
        .o_total  (n_total),
        .o_ctl    (ctl),
        .o_result (n_out)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
            r_init    <= 1'b0;
            r_poison  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= 1'b1;
            end else if (fire) begin
                r_pend <= 1'b0;
            end

            if (fire) begin
                r_out_vld <= 1'b1;
                r_total   <= n_total;
                r_init    <= ctl.init_n;
                r_poison  <= ctl.poison_n;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ----- dv/per_cpu_preemption_tracker_top_tb.sv -----
// Self-checking testbench for per_cpu_preemption_tracker_top: a directed
// opening, two counter climbs to overflow, then biased random events.
// Depends on pcpt_pkg and the RTL only.

module per_cpu_preemption_tracker_top_tb;
    import pcpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPUS          = CPU_COUNT_DEF;
    // Counts top out at the nesting limit or the 8-bit entry maximum, whichever is lower; one more step overflows
    localparam int DEPTH_CAP     = (NESTING_MAX_DEF < 255) ? NESTING_MAX_DEF : 255;
    localparam int RANDOM_EVENTS = 400;
    localparam int CALM_TAIL     = 100;
    localparam int WATCHDOG      = 2000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    per_cpu_preemption_tracker_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the tracker state, updated as each item is accepted
    // ------------------------------------------------------------------
    logic [7:0] cpu_irq     [CPUS];
    logic [7:0] cpu_pc      [CPUS];
    logic       cpu_resched [CPUS];
    logic       cpu_up      [CPUS];
    int         up_total;
    logic       is_init;
    logic       is_poisoned;

    t_in_item   events_pending [$];   // items waiting for the driver
    t_out_item  results_due    [$];   // predicted results, oldest first

    bit  in_fire, out_fire;
    bit  quiet;                       // no idling on either side
    int  gap_left, stall_left;
    int  cyc, idle_cycles;
    int  n_events, n_errors, n_poison, n_eligible, n_snaps;

    function automatic void wipe_tracker();
        for (int i = 0; i < CPUS; i++) begin
            cpu_irq[i]     = '0;
            cpu_pc[i]      = '0;
            cpu_resched[i] = 1'b0;
            cpu_up[i]      = 1'b0;
        end
        up_total    = 0;
        is_init     = 1'b0;
        is_poisoned = 1'b0;
    endfunction

    function automatic logic can_resched(int c);
        return cpu_up[c] && cpu_irq[c] == '0 && cpu_pc[c] == '0 && cpu_resched[c];
    endfunction

    // Expected result for one event; updates the shadow as the block would
    function automatic t_out_item track_event(t_in_item ev);
        t_out_item r;
        int        c;
        r = '0;
        c = ev.cpu_sel;
        if (ev.func == FN_INIT) begin
            // refused when already up, even with poison set
            if (is_init)
                r.status = ST_ALREADY_INIT;
            else if (c >= CPUS)
                r.status = ST_INVALID_CPU;
            else begin
                wipe_tracker();
                cpu_up[c] = 1'b1;
                up_total  = 1;
                is_init   = 1'b1;
            end
        end else if (ev.func == FN_CLEAR) begin
            wipe_tracker();
        end else if (ev.func > FN_CLEAR) begin
            // unused codes: no effect, ok status
        end else if (is_poisoned) begin
            r.status = ST_POISONED;
        end else if (!is_init) begin
            r.status = ST_NOT_INIT;
        end else if (c >= CPUS) begin
            r.status = ST_INVALID_CPU;
        end else if (ev.func == FN_ONLINE) begin
            if (cpu_up[c])
                r.status = ST_ALREADY_ONLINE;
            else begin
                cpu_up[c] = 1'b1;
                up_total++;
            end
        end else if (ev.func == FN_SNAPSHOT) begin
            // snapshot works on offline CPUs too
            r.snap_irq_lvl     = cpu_irq[c];
            r.snap_pre_cnt     = cpu_pc[c];
            r.snap_resched_req = cpu_resched[c];
            r.snap_online      = cpu_up[c];
        end else if (!cpu_up[c]) begin
            r.status = ST_OFFLINE;
        end else begin
            case (ev.func)
                FN_OFFLINE: begin
                    if (up_total <= 1)
                        r.status = ST_LAST_CPU;
                    else if (cpu_irq[c] != '0 || cpu_pc[c] != '0 || cpu_resched[c])
                        r.status = ST_BUSY;
                    else begin
                        cpu_up[c] = 1'b0;
                        up_total--;
                    end
                end
                FN_IRQ_ENTER: begin
                    if (cpu_irq[c] >= DEPTH_CAP) begin
                        is_poisoned = 1'b1;
                        r.status    = ST_OVERFLOW;
                    end else
                        cpu_irq[c]++;
                end
                FN_IRQ_EXIT: begin
                    if (cpu_irq[c] == '0) begin
                        is_poisoned = 1'b1;
                        r.status    = ST_UNDERFLOW;
                    end else begin
                        cpu_irq[c]--;
                        r.eligible = can_resched(c);
                    end
                end
                FN_DISABLE: begin
                    if (cpu_pc[c] >= DEPTH_CAP) begin
                        is_poisoned = 1'b1;
                        r.status    = ST_OVERFLOW;
                    end else
                        cpu_pc[c]++;
                end
                FN_ENABLE: begin
                    if (cpu_pc[c] == '0) begin
                        is_poisoned = 1'b1;
                        r.status    = ST_UNDERFLOW;
                    end else begin
                        cpu_pc[c]--;
                        r.eligible = can_resched(c);
                    end
                end
                FN_REQUEST: cpu_resched[c] = 1'b1;
                FN_CANCEL:  cpu_resched[c] = 1'b0;
                FN_QUERY:   r.eligible = can_resched(c);
                FN_TAKE: begin
                    if (!can_resched(c))
                        r.status = ST_NOT_ELIGIBLE;
                    else
                        cpu_resched[c] = 1'b0;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH at result %0d, %s: got %0d, want %0d",
                 n_events - results_due.size(), what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts on input accept, checks on output accept, and
    // ends the run if the handshakes stop moving.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        cyc++;
        if (in_fire) begin
            want = track_event(in_item);
            results_due.push_back(want);
            n_events++;
            if (want.status == ST_OVERFLOW || want.status == ST_UNDERFLOW)
                n_poison++;
            if (want.eligible)
                n_eligible++;
            if (in_item.func == FN_SNAPSHOT && want.status == ST_OK)
                n_snaps++;
        end
        if (out_fire) begin
            if (results_due.size() == 0)
                flag_mismatch("result with none due", out_item.status, 0);
            else begin
                want = results_due.pop_front();
                if (out_item.status !== want.status)
                    flag_mismatch("status", out_item.status, want.status);
                if (out_item.eligible !== want.eligible)
                    flag_mismatch("eligible", out_item.eligible, want.eligible);
                if (out_item.snap_irq_lvl !== want.snap_irq_lvl)
                    flag_mismatch("snap_irq_lvl", out_item.snap_irq_lvl,
                                  want.snap_irq_lvl);
                if (out_item.snap_pre_cnt !== want.snap_pre_cnt)
                    flag_mismatch("snap_pre_cnt", out_item.snap_pre_cnt,
                                  want.snap_pre_cnt);
                if (out_item.snap_resched_req !== want.snap_resched_req)
                    flag_mismatch("snap_resched_req", out_item.snap_resched_req,
                                  want.snap_resched_req);
                if (out_item.snap_online !== want.snap_online)
                    flag_mismatch("snap_online", out_item.snap_online, want.snap_online);
            end
        end
        idle_cycles = (!rst_n || in_fire || out_fire) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results still due",
                     WATCHDOG, results_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Idling is switched off in one window out of three and in the tail
    function automatic bit idle_allowed();
        return !quiet && ((cyc >> 7) % 3 != 0);
    endfunction

    // Driver: moves to the next item only once the current one is taken
    always @(negedge clk) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 15);
                in_valid <= 1'b0;
            end else if (events_pending.size() > 0) begin
                in_item  <= events_pending.pop_front();
                in_valid <= 1'b1;
            end else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stalls in bursts of random length
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_event(logic [3:0] fn, logic [7:0] cpu);
        t_in_item ev;
        // keep the queue short so random choices see a fresh shadow
        while (events_pending.size() >= 4)
            @(posedge clk);
        ev.func    = fn;
        ev.cpu_sel = cpu;
        events_pending.push_back(ev);
    endtask

    task automatic drain_all();
        while (events_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
    endtask

    // Walk a counter up to its cap, overflow it, then clear the block
    task automatic climb_to_overflow(logic [3:0] up_fn, logic [7:0] cpu);
        queue_event(FN_INIT, cpu);
        repeat (DEPTH_CAP) queue_event(up_fn, cpu);
        queue_event(FN_SNAPSHOT, cpu);
        queue_event(up_fn, cpu);
        queue_event(FN_SNAPSHOT, cpu);
        queue_event(FN_CLEAR, cpu);
    endtask

    // Keep nesting shallow and underflow rare
    function automatic logic [3:0] balance(logic [3:0] fn, logic [7:0] lvl,
                                           logic [3:0] up_fn, logic [3:0] down_fn);
        if (fn == down_fn && lvl == '0 && $urandom_range(0, 15) != 0)
            return up_fn;
        if (fn == up_fn && lvl >= 3 && $urandom_range(0, 1) == 0)
            return down_fn;
        return fn;
    endfunction

    task automatic pick_random(output logic [3:0] fn, output logic [7:0] cpu);
        int roll;
        if ($urandom_range(0, 9) == 0)
            cpu = $urandom_range(CPUS, 255);
        else if ($urandom_range(0, 1) == 0)
            cpu = $urandom_range(0, 3);
        else
            cpu = $urandom_range(0, CPUS - 1);

        roll = $urandom_range(0, 99);
        if (is_poisoned && $urandom_range(0, 3) != 0)
            fn = FN_CLEAR;
        else if (!is_init && $urandom_range(0, 4) != 0) begin
            fn  = FN_INIT;
            cpu = $urandom_range(0, 3);
        end
        else if (roll < 2)  fn = FN_INIT;
        else if (roll < 12) fn = FN_ONLINE;
        else if (roll < 20) fn = FN_OFFLINE;
        else if (roll < 31) fn = FN_IRQ_ENTER;
        else if (roll < 42) fn = FN_IRQ_EXIT;
        else if (roll < 53) fn = FN_DISABLE;
        else if (roll < 64) fn = FN_ENABLE;
        else if (roll < 74) fn = FN_REQUEST;
        else if (roll < 78) fn = FN_CANCEL;
        else if (roll < 85) fn = FN_QUERY;
        else if (roll < 93) fn = FN_TAKE;
        else if (roll < 97) fn = FN_SNAPSHOT;
        else if (roll < 98) fn = FN_CLEAR;
        else                fn = FN_CLEAR + 4'($urandom_range(1, 3));

        if (cpu < CPUS) begin
            fn = balance(fn, cpu_irq[cpu], FN_IRQ_ENTER, FN_IRQ_EXIT);
            fn = balance(fn, cpu_pc[cpu], FN_DISABLE, FN_ENABLE);
        end
    endtask

    initial begin
        logic [3:0] fn;
        logic [7:0] cpu;
        wipe_tracker();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: gate order, boot rules, offline rules, eligibility
        queue_event(FN_QUERY, 8'd0);                // before init
        queue_event(FN_INIT, 8'd255);               // invalid boot CPU
        queue_event(FN_INIT, 8'd0);
        queue_event(FN_INIT, 8'd15);                // already up
        queue_event(FN_ONLINE, 8'd0);               // already online
        queue_event(FN_OFFLINE, 8'd0);              // only CPU left
        queue_event(FN_ONLINE, 8'd15);
        queue_event(FN_QUERY, 8'd7);                // offline CPU
        queue_event(FN_SNAPSHOT, 8'd7);             // snapshot of an offline CPU
        queue_event(FN_SNAPSHOT, 8'd16);            // first invalid index
        queue_event(FN_REQUEST, 8'd15);
        queue_event(FN_TAKE, 8'd15);
        queue_event(FN_TAKE, 8'd15);                // nothing left to take
        queue_event(FN_IRQ_ENTER, 8'd15);
        queue_event(FN_DISABLE, 8'd15);
        queue_event(FN_REQUEST, 8'd15);
        queue_event(FN_SNAPSHOT, 8'd15);            // every field set
        queue_event(FN_OFFLINE, 8'd15);             // busy
        queue_event(FN_IRQ_EXIT, 8'd15);            // still disabled
        queue_event(FN_ENABLE, 8'd15);              // becomes eligible
        queue_event(FN_QUERY, 8'd15);
        queue_event(FN_CANCEL, 8'd15);
        queue_event(FN_OFFLINE, 8'd15);
        queue_event(FN_CLEAR + 4'd1, 8'd170);       // unused codes
        queue_event(FN_CLEAR + 4'd3, 8'd85);
        queue_event(FN_ENABLE, 8'd0);               // underflow poisons
        queue_event(FN_QUERY, 8'd0);
        queue_event(FN_INIT, 8'd0);                 // refused even when poisoned
        queue_event(FN_CLEAR, 8'd0);

        // Let everything come back before moving on
        drain_all();

        climb_to_overflow(FN_IRQ_ENTER, 8'd4);
        climb_to_overflow(FN_DISABLE, 8'd11);

        for (int k = 0; k < RANDOM_EVENTS; k++) begin
            quiet = (k >= RANDOM_EVENTS - CALM_TAIL);
            pick_random(fn, cpu);
            queue_event(fn, cpu);
        end

        drain_all();
        repeat (10) @(posedge clk);

        $display("Ran %0d events through init, hotplug, nesting, overflow and clear paths;",
                 n_events);
        $display("%0d poisoning events, %0d eligible results, %0d snapshots, %0d mismatches",
                 n_poison, n_eligible, n_snaps, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
